@@ rtl/core/fwgr_pkg.sv @@
// Package: shared constants and types of the full weighting restriction block.
`timescale 1ns / 1ps
`default_nettype none

package fwgr_pkg;

  // Width and reset value of the fine_size register
  localparam int unsigned FINE_SIZE_WIDTH = 11;
  localparam logic [FINE_SIZE_WIDTH-1:0] FINE_SIZE_RESET = 11'd1025;

  // Where an accepted sample sits relative to the coarse grid
  typedef struct packed {
    logic emit;      // a coarse point completes at this sample
    logic interior;  // that coarse point is interior (weighted sum, else zero)
    logic last;      // that coarse point closes the grid
  } pos_t;

endpackage

`default_nettype wire

@@ rtl/core/frg_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module frg_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1025
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while the read enable is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/frg_scan.sv @@
// Scan position tracking: fine_size register, row and column counters, coarse point flags.
`timescale 1ns / 1ps
`default_nettype none

module frg_scan
  import fwgr_pkg::*;
#(
  parameter int unsigned MAX_FINE_SIZE = 1025
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [FINE_SIZE_WIDTH-1:0]         cfg_size_i,
  input  wire logic                               adv_i,
  output pos_t                                    pos_o,
  output logic      [$clog2(MAX_FINE_SIZE)-1:0]   col_o
);

  localparam int unsigned NW = $clog2(MAX_FINE_SIZE + 1);
  localparam int unsigned CW = $clog2(MAX_FINE_SIZE);
  localparam int unsigned EW = (NW > FINE_SIZE_WIDTH) ? NW : FINE_SIZE_WIDTH;

  // Clamp to the supported range, then round an even size down to odd
  function automatic logic [NW-1:0] eff_size(input logic [FINE_SIZE_WIDTH-1:0] v);
    logic [EW-1:0] x;
    x = EW'(v);
    if (x < EW'(3)) x = EW'(3);
    if (x > EW'(MAX_FINE_SIZE)) x = EW'(MAX_FINE_SIZE);
    if (!x[0]) x = x - EW'(1);
    return NW'(x);
  endfunction

  localparam logic [NW-1:0] SizeReset = eff_size(FINE_SIZE_RESET);

  logic [NW-1:0] size_q, size_d;
  logic [CW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [NW-1:0] size_m1;
  logic [NW-1:0] row_inc, col_inc;
  logic          row_end, col_end;
  logic          row_emit, col_emit;

  assign size_m1 = size_q - NW'(1);
  assign row_inc = NW'(row_q) + NW'(1);
  assign col_inc = NW'(col_q) + NW'(1);
  assign row_end = (NW'(row_q) == size_m1);
  assign col_end = (NW'(col_q) == size_m1);

  // Coarse point completes on odd rows/columns and on the final row/column
  assign row_emit = row_end || row_q[0];
  assign col_emit = col_end || col_q[0];

  // Interior: odd index of at least 3 (odd indices never reach the last line)
  always_comb begin
    pos_o.emit     = row_emit && col_emit;
    pos_o.interior = row_q[0] && (row_q != CW'(1)) && col_q[0] && (col_q != CW'(1));
    pos_o.last     = row_end && col_end;
  end

  assign col_o = col_q;

  // Counter and size update; a size write restarts the grid
  always_comb begin
    size_d = size_q;
    row_d  = row_q;
    col_d  = col_q;
    if (cfg_we_i) begin
      size_d = eff_size(cfg_size_i);
      row_d  = '0;
      col_d  = '0;
    end else if (adv_i) begin
      if (col_inc >= size_q) begin
        col_d = '0;
        row_d = (row_inc >= size_q) ? '0 : CW'(row_inc);
      end else begin
        col_d = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
      row_q  <= '0;
      col_q  <= '0;
    end else begin
      size_q <= size_d;
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/frg_window.sv @@
// 3x3 window registers and the full weighting sum (result scaled by 16).
`timescale 1ns / 1ps
`default_nettype none

module frg_window #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  wire logic                           clk_i,
  input  wire logic                           adv_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] older_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] prev_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic      signed [SAMPLE_WIDTH+3:0] sum_o
);

  localparam int unsigned OW = SAMPLE_WIDTH + 4;

  // Columns c-2 and c-1 of rows r-2, r-1 and r
  logic signed [SAMPLE_WIDTH-1:0] w_q [6];
  logic signed [OW-1:0] centre, edges, corners;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      w_q[0] <= w_q[1];
      w_q[1] <= older_i;
      w_q[2] <= w_q[3];
      w_q[3] <= prev_i;
      w_q[4] <= w_q[5];
      w_q[5] <= sample_i;
    end
  end

  // 4*centre + 2*edges + corners
  always_comb begin
    centre  = OW'(w_q[3]);
    edges   = OW'(w_q[1]) + OW'(w_q[5]) + OW'(w_q[2]) + OW'(prev_i);
    corners = OW'(w_q[0]) + OW'(older_i) + OW'(w_q[4]) + OW'(sample_i);
    sum_o   = (centre <<< 2) + (edges <<< 1) + corners;
  end

endmodule

`default_nettype wire

@@ rtl/core/full_weighting_grid_restriction.sv @@
// Top level: streamed 2D full weighting restriction of a fine grid onto its coarse grid.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_fine_size_i
//   in      | in        | in_valid_i  / in_ready_o  | sample_i
//   out     | out       | out_valid_o / out_ready_i | coarse_value_o, last_o
//
// One sample per cycle. A sample is registered in stage 1 with its line buffer
// read, and from there the window sum is loaded into the output register. Each
// sample updates the line buffer RAM (one write and one read port) exactly once.
// The input stalls only when a result is due while the output register is still
// held. The line buffers need no clearing after reset: an interior point only
// uses rows of the current grid.
`timescale 1ns / 1ps
`default_nettype none

module full_weighting_grid_restriction
  import fwgr_pkg::*;
#(
  parameter int unsigned MAX_FINE_SIZE = 1025,
  parameter int unsigned SAMPLE_WIDTH  = 24
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [FINE_SIZE_WIDTH-1:0]     cfg_fine_size_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH+3:0]      coarse_value_o,
  output logic                                last_o
);

  localparam int unsigned CW = $clog2(MAX_FINE_SIZE);
  localparam int unsigned OW = SAMPLE_WIDTH + 4;

  logic                           cfg_fire, in_fire;
  pos_t                           pos;
  logic [CW-1:0]                  col;

  logic                           s1_valid_q, s1_valid_d;
  pos_t                           s1_pos_q;
  logic [CW-1:0]                  s1_col_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_q;
  logic                           s1_go, out_free;

  logic [2*SAMPLE_WIDTH-1:0]      ram_rdata, ram_wdata;
  logic signed [SAMPLE_WIDTH-1:0] older, prev;
  logic signed [OW-1:0]           sum;

  logic                           out_valid_q, out_valid_d;
  logic signed [OW-1:0]           coarse_q;
  logic                           last_q;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_go       = s1_valid_q && (!s1_pos_q.emit || out_free);
  assign in_ready_o  = !s1_valid_q || s1_go;
  assign in_fire     = in_valid_i && in_ready_o;

  frg_scan #(
    .MAX_FINE_SIZE(MAX_FINE_SIZE)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_fire),
    .cfg_size_i(cfg_fine_size_i),
    .adv_i     (in_fire),
    .pos_o     (pos),
    .col_o     (col)
  );

  // Line buffers: {older row, previous row} at each column
  assign ram_wdata = {prev, s1_sample_q};

  frg_ram #(
    .WIDTH(2 * SAMPLE_WIDTH),
    .DEPTH(MAX_FINE_SIZE)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_go),
    .waddr_i(s1_col_q),
    .wdata_i(ram_wdata),
    .re_i   (in_fire),
    .raddr_i(col),
    .rdata_o(ram_rdata)
  );

  assign older = ram_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign prev  = ram_rdata[SAMPLE_WIDTH-1:0];

  frg_window #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_window (
    .clk_i   (clk_i),
    .adv_i   (s1_go),
    .older_i (older),
    .prev_i  (prev),
    .sample_i(s1_sample_q),
    .sum_o   (sum)
  );

  // Stage 1: sample with its position, waiting on the line buffer read
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_go);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pos_q    <= pos;
      s1_col_q    <= col;
      s1_sample_q <= sample_i;
    end
  end

  // Output register; boundary points give zero
  assign out_valid_d = (s1_go && s1_pos_q.emit) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_pos_q.emit) begin
      coarse_q <= s1_pos_q.interior ? sum : '0;
      last_q   <= s1_pos_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coarse_value_o = coarse_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

@@ rtl/core/frg_checker.sv @@
// Port-level assertions for the full weighting restriction block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module frg_checker #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic signed [SAMPLE_WIDTH+3:0] coarse_value_o,
  input wire logic                           last_o
);

  // A held result keeps its payload until the transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(coarse_value_o) && $stable(last_o))
    else $error("result changed while stalled");

  // The grid closes on a boundary point, which is zero
  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> coarse_value_o == '0)
    else $error("closing coarse point is not zero");

  // Input is held back only while a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with no result pending");

endmodule

bind full_weighting_grid_restriction frg_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_frg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .coarse_value_o(coarse_value_o),
  .last_o        (last_o)
);

`default_nettype wire

@@ test/testbench.sv @@
// Testbench: streams fine grids through the full weighting restriction block and checks every coarse point.
`timescale 1ns / 1ps

module testbench;
  import fwgr_pkg::*;

  localparam int unsigned MAX_SIDE    = 1025;
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned OUT_W       = SAMPLE_W + 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 4;   // two pipeline registers plus margin
  localparam int unsigned RANDOM_GOAL = 300;

  typedef enum int unsigned {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_CORNERS} fill_e;
  typedef enum int unsigned {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_style_e;

  // Grid model plus the queue of coarse points still owed by the block
  class coarse_scoreboard;
    typedef struct {
      logic signed [OUT_W-1:0] value;
      logic                    last;
    } coarse_t;

    logic signed [SAMPLE_W-1:0] older_row [MAX_SIDE];
    logic signed [SAMPLE_W-1:0] recent_row[MAX_SIDE];
    logic signed [SAMPLE_W-1:0] win[6];
    int unsigned row_at, col_at, side;
    coarse_t owed[$];
    int unsigned errors;

    function new();
      foreach (older_row[k]) begin
        older_row[k]  = '0;
        recent_row[k] = '0;
      end
      foreach (win[k]) win[k] = '0;
      row_at = 0;
      col_at = 0;
      side   = clamp_side(FINE_SIZE_RESET);
      errors = 0;
    endfunction

    static function int unsigned clamp_side(int unsigned v);
      int unsigned n;
      n = v;
      if (n < 3) n = 3;
      if (n > MAX_SIDE) n = MAX_SIDE;
      if (n[0] == 1'b0) n = n - 1;
      return n;
    endfunction

    // A size write restarts the grid; row buffers and window keep their data
    function void restart(int unsigned v);
      side   = clamp_side(v);
      row_at = 0;
      col_at = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      int unsigned m, ci, cj;
      bit row_hit, col_hit;
      longint o, p, acc;
      coarse_t exp_pt;
      m = (side + 1) / 2;
      ci = 0;
      cj = 0;
      o = older_row[col_at];
      p = recent_row[col_at];
      // coarse row / column completed by this sample
      row_hit = 1'b1;
      if (row_at == side - 1) ci = m - 1;
      else if (row_at[0]) ci = (row_at - 1) / 2;
      else row_hit = 1'b0;
      col_hit = 1'b1;
      if (col_at == side - 1) cj = m - 1;
      else if (col_at[0]) cj = (col_at - 1) / 2;
      else col_hit = 1'b0;
      if (row_hit && col_hit) begin
        acc = 0;
        if (ci >= 1 && ci + 2 <= m && cj >= 1 && cj + 2 <= m) begin
          acc = 4 * longint'(win[3])
              + 2 * (longint'(win[1]) + longint'(win[5]) + longint'(win[2]) + p)
              + (longint'(win[0]) + o + longint'(win[4]) + longint'(s));
        end
        exp_pt.value = acc[OUT_W-1:0];
        exp_pt.last  = (ci == m - 1) && (cj == m - 1);
        owed = {owed, exp_pt};
      end
      // slide window, rotate line buffers
      win[0] = win[1]; win[1] = o[SAMPLE_W-1:0];
      win[2] = win[3]; win[3] = p[SAMPLE_W-1:0];
      win[4] = win[5]; win[5] = s;
      older_row[col_at]  = p[SAMPLE_W-1:0];
      recent_row[col_at] = s;
      col_at++;
      if (col_at >= side) begin
        col_at = 0;
        row_at++;
        if (row_at >= side) row_at = 0;
      end
    endfunction

    function void check_result(logic signed [OUT_W-1:0] value, logic last);
      coarse_t exp_pt;
      if (owed.size() == 0) begin
        $display("%0t: unexpected coarse point, got value %0d last %0b", $time, value, last);
        errors++;
        return;
      end
      exp_pt = owed.pop_front();
      if (value !== exp_pt.value) begin
        $display("%0t: coarse_value expected %0d, got %0d", $time, exp_pt.value, value);
        errors++;
      end
      if (last !== exp_pt.last) begin
        $display("%0t: last expected %0b, got %0b", $time, exp_pt.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [FINE_SIZE_WIDTH-1:0]     cfg_fine_size_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic signed [SAMPLE_W-1:0]     sample_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic signed [OUT_W-1:0]        coarse_value_o;
  logic                           last_o;

  coarse_scoreboard grid_sb;
  int unsigned cycle_count;
  int unsigned results_seen;
  int unsigned burst_left;
  int unsigned random_items;
  int unsigned large_budget;

  full_weighting_grid_restriction #(
    .MAX_FINE_SIZE(MAX_SIDE),
    .SAMPLE_WIDTH (SAMPLE_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_fine_size_i(cfg_fine_size_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .coarse_value_o (coarse_value_o),
    .last_o         (last_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Transfer monitor: inputs feed the model, outputs are checked against it
  initial results_seen = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) grid_sb.note_sample(sample_i);
      if (out_valid_o && out_ready_i) begin
        grid_sb.check_result(coarse_value_o, last_o);
        results_seen++;
      end
    end
  end

  // Receiver: changing stall styles, plus two long hold-offs
  initial begin
    int unsigned seg_left;
    int unsigned hold_left;
    rx_style_e style;
    bit first_hold_done, second_hold_done;
    seg_left = 0;
    hold_left = 0;
    style = RX_ALWAYS;
    first_hold_done = 1'b0;
    second_hold_done = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!first_hold_done && results_seen >= 20) begin
        hold_left = 500;
        first_hold_done = 1'b1;
      end
      if (!second_hold_done && results_seen >= 60) begin
        hold_left = 300;
        second_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 200);
          style = rx_style_e'($urandom_range(0, 3));
        end
        seg_left--;
        case (style)
          RX_ALWAYS: out_ready_i <= 1'b1;
          RX_HALF:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:   out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(fill_e fill);
    logic signed [SAMPLE_W-1:0] v;
    v = SAMPLE_W'($urandom);
    case (fill)
      FILL_MAX: v = {1'b0, {(SAMPLE_W-1){1'b1}}};
      FILL_MIN: v = {1'b1, {(SAMPLE_W-1){1'b0}}};
      FILL_CORNERS: begin
        case ($urandom_range(0, 4))
          0: v = {1'b0, {(SAMPLE_W-1){1'b1}}};
          1: v = {1'b1, {(SAMPLE_W-1){1'b0}}};
          2: v = '0;
          3: v = '1;
          default: ;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // Wait until no coarse point is owed, then let the pipeline settle
  task automatic wait_drained();
    while (grid_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_size(int unsigned v);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_fine_size_i <= v[FINE_SIZE_WIDTH-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    grid_sb.restart(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Send samples in bursts with random gaps; now and then pause until drained
  task automatic send_stream(int unsigned count, fill_e fill);
    int unsigned gap;
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 299) == 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        wait_drained();
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
        burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clk_i);
      in_valid_i <= 1'b1;
      sample_i   <= pick_sample(fill);
      do @(posedge clk_i); while (!in_ready_o);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned pick, cfg_val, n, count;
    fill_e fill;
    grid_sb = new();
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_fine_size_i = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    burst_left = 0;
    random_items = 0;
    large_budget = 2;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Size from reset: one full row and the first coarse points of the next
    send_stream(MAX_SIDE + 8, FILL_CORNERS);

    // Directed: smallest grids, clamped sizes, full-scale sums
    write_size(0);
    send_stream(9, FILL_CORNERS);
    write_size(2);
    send_stream(9, FILL_RANDOM);
    write_size(6);
    send_stream(25, FILL_MAX);
    write_size(5);
    send_stream(25, FILL_MIN);
    write_size(7);
    send_stream(20, FILL_CORNERS);   // grid cut short by the next write

    // Random grids: mostly small; the largest sizes only briefly
    while (random_items < RANDOM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 3 && large_budget > 0) begin
        large_budget--;
        case ($urandom_range(0, 3))
          0: cfg_val = 1024;
          1: cfg_val = 1025;
          2: cfg_val = 1026;
          default: cfg_val = 2047;
        endcase
      end else if (pick < 12) begin
        cfg_val = $urandom_range(0, 4);
      end else begin
        cfg_val = $urandom_range(3, 21);
      end
      n = coarse_scoreboard::clamp_side(cfg_val);
      pick = $urandom_range(0, 99);
      if (n > 100) count = $urandom_range(1, 40);
      else if (pick < 60) count = n * n;
      else if (pick < 75) count = n * n * $urandom_range(2, 3);
      else count = $urandom_range(1, n * n - 1);
      if (count > RANDOM_GOAL - random_items) count = RANDOM_GOAL - random_items;
      pick = $urandom_range(0, 9);
      if (pick == 0) fill = FILL_MAX;
      else if (pick == 1) fill = FILL_MIN;
      else if (pick < 6) fill = FILL_CORNERS;
      else fill = FILL_RANDOM;
      write_size(cfg_val);
      send_stream(count, fill);
      random_items += count;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (grid_sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
